// File: hw/rtl/rsmp_pkg.sv
// Shared constants, types and helper functions of the range sector min-pool block.
package rsmp_pkg;

  localparam int unsigned NUM_SECTORS = 36;
  localparam int unsigned RANGE_WIDTH = 16;
  localparam int unsigned LEN_W       = 12;
  localparam int unsigned SECTOR_W    = $clog2(NUM_SECTORS + 1);
  localparam int unsigned MIN_W       = 14;
  localparam int unsigned VALUE_W     = 16;

  localparam int unsigned RANGE_LO   = 500;
  localparam int unsigned RANGE_HI   = 10000;
  localparam int unsigned RANGE_SPAN = RANGE_HI - RANGE_LO;
  localparam int unsigned FULL_SCALE = 65535;

  // floor(len / NUM_SECTORS) as a multiply by a rounded-up reciprocal
  localparam int unsigned SEC_SHIFT = 18;
  localparam int unsigned SEC_MUL   = ((2 ** SEC_SHIFT) + NUM_SECTORS - 1) / NUM_SECTORS;
  localparam int unsigned SEC_MUL_W = $clog2(SEC_MUL + 1);

  // (d * FULL_SCALE) / RANGE_SPAN estimate, low by at most one
  localparam int unsigned NORM_SHIFT = 24;
  localparam int unsigned NORM_MUL_W = 27;
  localparam logic [NORM_MUL_W-1:0] NORM_MUL =
    NORM_MUL_W'((64'(FULL_SCALE) << NORM_SHIFT) / 64'(RANGE_SPAN));
  localparam int unsigned PROD_W = MIN_W + NORM_MUL_W;
  localparam int unsigned REM_W  = MIN_W + VALUE_W;

  typedef struct packed {
    logic [SECTOR_W-1:0] sector;
    logic                done;
    logic                full;
  } res_meta_t;

  function automatic logic [LEN_W-1:0] sector_width(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0]           n;
    logic [LEN_W+SEC_MUL_W-1:0] prod;
    logic [LEN_W-1:0]           q;
    n    = (len == '0) ? LEN_W'(1) : len;
    prod = (LEN_W + SEC_MUL_W)'(n) * (LEN_W + SEC_MUL_W)'(SEC_MUL);
    q    = LEN_W'(prod >> SEC_SHIFT);
    if (q == '0) begin
      q = LEN_W'(1);
    end
    return q;
  endfunction

endpackage

// File: hw/rtl/rsmp_if.sv
// Request channels of the range sector min-pool block: range samples in, sector results out.
interface rsmp_in_if;
  logic                              valid;
  logic                              ready;
  logic [rsmp_pkg::RANGE_WIDTH-1:0]  range_mm;
  logic                              range_finite;

  modport source (output valid, output range_mm, output range_finite, input ready);
  modport sink   (input valid, input range_mm, input range_finite, output ready);
endinterface

interface rsmp_out_if;
  logic                           valid;
  logic                           ready;
  logic [rsmp_pkg::VALUE_W-1:0]   sector_value;
  logic [rsmp_pkg::SECTOR_W-1:0]  sector_number;
  logic                           scan_done;

  modport source (output valid, output sector_value, output sector_number,
                  output scan_done, input ready);
  modport sink   (input valid, input sector_value, input sector_number,
                  input scan_done, output ready);
endinterface

// File: hw/rtl/rsmp_norm.sv
// Two-step normalisation of a sector minimum to a 16-bit fraction of full scale.
module rsmp_norm (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_vld,
  input  logic [rsmp_pkg::MIN_W-1:0]   in_d,
  input  rsmp_pkg::res_meta_t          in_meta,
  output logic                         res_vld,
  output logic [rsmp_pkg::VALUE_W-1:0] res_value,
  output rsmp_pkg::res_meta_t          res_meta
);

  logic                          vld_r;
  logic [rsmp_pkg::MIN_W-1:0]    d_r;
  logic [rsmp_pkg::PROD_W-1:0]   prod_r;
  rsmp_pkg::res_meta_t           meta_r;

  logic [rsmp_pkg::VALUE_W-1:0]  q_est;
  logic [rsmp_pkg::REM_W-1:0]    scaled;
  logic [rsmp_pkg::REM_W-1:0]    rem;
  logic [rsmp_pkg::VALUE_W-1:0]  q_fix;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r    <= in_d;
      meta_r <= in_meta;
      prod_r <= rsmp_pkg::PROD_W'(in_d) * rsmp_pkg::PROD_W'(rsmp_pkg::NORM_MUL);
    end
  end

  // estimate is low by at most one; check the remainder and bump once
  always_comb begin
    q_est  = prod_r[rsmp_pkg::NORM_SHIFT +: rsmp_pkg::VALUE_W];
    scaled = (rsmp_pkg::REM_W'(d_r) << rsmp_pkg::VALUE_W) - rsmp_pkg::REM_W'(d_r);
    rem    = scaled - rsmp_pkg::REM_W'(q_est) * rsmp_pkg::REM_W'(rsmp_pkg::RANGE_SPAN);
    q_fix  = (rem >= rsmp_pkg::REM_W'(rsmp_pkg::RANGE_SPAN)) ? (q_est + 1'b1) : q_est;
  end

  assign res_vld   = vld_r;
  assign res_meta  = meta_r;
  assign res_value = meta_r.full ? rsmp_pkg::VALUE_W'(rsmp_pkg::FULL_SCALE) : q_fix;

endmodule

// File: hw/rtl/range_sector_min_pool_core.sv
// Top level of the range sector min-pool block: sector tracking, flush and result register.
// Takes one range sample per cycle unless the output is held or a flush runs, and pools
// each scan into 36 sectors, reporting the nearest clamped range of every sector as a
// 16-bit fraction of 9500 mm above 500 mm. Compare and running-minimum update feed the
// first-stage register, the normalising multiply the normaliser register, its correction
// the result register. When a scan shorter than 36 samples ends, the sectors not yet
// reached are sent as 65535 one per cycle while the output is not held, and no sample is
// taken during that flush. cfg_wr_data is the scan length; 0 counts as 1, and the block must
// be idle when it is written. The output register stalls the whole pipeline when held.
module range_sector_min_pool_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [rsmp_pkg::LEN_W-1:0]    cfg_wr_data,
  rsmp_in_if.sink                       in_ch,
  rsmp_out_if.source                    out_ch
);

  localparam logic [rsmp_pkg::SECTOR_W-1:0] LAST_SECTOR =
    rsmp_pkg::SECTOR_W'(rsmp_pkg::NUM_SECTORS - 1);
  localparam logic [rsmp_pkg::SECTOR_W-1:0] SECTOR_END =
    rsmp_pkg::SECTOR_W'(rsmp_pkg::NUM_SECTORS);

  // configuration
  logic [rsmp_pkg::LEN_W-1:0]    scan_len_r;
  logic [rsmp_pkg::LEN_W-1:0]    sec_len_r;

  // scan state
  logic [rsmp_pkg::LEN_W-1:0]    sample_cnt_r, sample_cnt_nxt;
  logic [rsmp_pkg::SECTOR_W-1:0] cur_sector_r, cur_sector_nxt;
  logic [rsmp_pkg::LEN_W-1:0]    pos_r, pos_nxt;
  logic [rsmp_pkg::MIN_W-1:0]    min_r, min_nxt;
  logic                          flush_r, flush_nxt;
  logic [rsmp_pkg::SECTOR_W-1:0] flush_sec_r, flush_sec_nxt;

  // first pipeline stage
  logic                          s1_vld_r, s1_vld_nxt;
  logic [rsmp_pkg::MIN_W-1:0]    s1_d_r, s1_d_nxt;
  rsmp_pkg::res_meta_t           s1_meta_r, s1_meta_nxt;

  // result register
  logic                          out_vld_r;
  logic [rsmp_pkg::VALUE_W-1:0]  out_value_r;
  rsmp_pkg::res_meta_t           out_meta_r;

  logic                          adv;
  logic                          accept;
  logic                          active;
  logic                          last;
  logic                          close;
  logic [rsmp_pkg::MIN_W-1:0]    clamped;
  logic [rsmp_pkg::MIN_W-1:0]    min_upd;

  logic                          nrm_vld;
  logic [rsmp_pkg::VALUE_W-1:0]  nrm_value;
  rsmp_pkg::res_meta_t           nrm_meta;

  assign adv         = !out_vld_r || out_ch.ready;
  assign in_ch.ready = adv && !flush_r;
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_len_r <= rsmp_pkg::LEN_W'(720);
      sec_len_r  <= rsmp_pkg::sector_width(rsmp_pkg::LEN_W'(720));
    end else if (cfg_wr_en) begin
      scan_len_r <= (cfg_wr_data == '0) ? rsmp_pkg::LEN_W'(1) : cfg_wr_data;
      sec_len_r  <= rsmp_pkg::sector_width(cfg_wr_data);
    end
  end

  always_comb begin
    if (in_ch.range_mm < rsmp_pkg::RANGE_WIDTH'(rsmp_pkg::RANGE_LO)) begin
      clamped = rsmp_pkg::MIN_W'(rsmp_pkg::RANGE_LO);
    end else if (in_ch.range_mm > rsmp_pkg::RANGE_WIDTH'(rsmp_pkg::RANGE_HI)) begin
      clamped = rsmp_pkg::MIN_W'(rsmp_pkg::RANGE_HI);
    end else begin
      clamped = rsmp_pkg::MIN_W'(in_ch.range_mm);
    end
    min_upd = (in_ch.range_finite && clamped < min_r) ? clamped : min_r;
    active  = cur_sector_r < SECTOR_END;
    last    = ((rsmp_pkg::LEN_W + 1)'(sample_cnt_r) + 1'b1) >= (rsmp_pkg::LEN_W + 1)'(scan_len_r);
    close   = active &&
              ((((rsmp_pkg::LEN_W + 1)'(pos_r) + 1'b1) >= (rsmp_pkg::LEN_W + 1)'(sec_len_r))
               || last);
  end

  always_comb begin
    sample_cnt_nxt = sample_cnt_r;
    cur_sector_nxt = cur_sector_r;
    pos_nxt        = pos_r;
    min_nxt        = min_r;
    flush_nxt      = flush_r;
    flush_sec_nxt  = flush_sec_r;
    s1_vld_nxt     = 1'b0;
    s1_d_nxt       = min_upd - rsmp_pkg::MIN_W'(rsmp_pkg::RANGE_LO);
    s1_meta_nxt    = '{sector: cur_sector_r, done: cur_sector_r == LAST_SECTOR, full: 1'b0};

    if (flush_r) begin
      // send the unreached sectors of a short scan as full scale
      s1_vld_nxt  = 1'b1;
      s1_meta_nxt = '{sector: flush_sec_r, done: flush_sec_r == LAST_SECTOR, full: 1'b1};
      if (flush_sec_r == LAST_SECTOR) begin
        flush_nxt = 1'b0;
      end else begin
        flush_sec_nxt = flush_sec_r + 1'b1;
      end
    end else if (accept) begin
      if (active) begin
        if (close) begin
          s1_vld_nxt     = 1'b1;
          cur_sector_nxt = cur_sector_r + 1'b1;
          pos_nxt        = '0;
          min_nxt        = rsmp_pkg::MIN_W'(rsmp_pkg::RANGE_HI);
        end else begin
          pos_nxt = pos_r + 1'b1;
          min_nxt = min_upd;
        end
      end
      if (last) begin
        sample_cnt_nxt = '0;
        cur_sector_nxt = '0;
        pos_nxt        = '0;
        min_nxt        = rsmp_pkg::MIN_W'(rsmp_pkg::RANGE_HI);
        if (active && cur_sector_r != LAST_SECTOR) begin
          flush_nxt     = 1'b1;
          flush_sec_nxt = cur_sector_r + 1'b1;
        end
      end else begin
        sample_cnt_nxt = sample_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_cnt_r <= '0;
      cur_sector_r <= '0;
      pos_r        <= '0;
      min_r        <= rsmp_pkg::MIN_W'(rsmp_pkg::RANGE_HI);
      flush_r      <= 1'b0;
      flush_sec_r  <= '0;
      s1_vld_r     <= 1'b0;
      out_vld_r    <= 1'b0;
    end else if (adv) begin
      sample_cnt_r <= sample_cnt_nxt;
      cur_sector_r <= cur_sector_nxt;
      pos_r        <= pos_nxt;
      min_r        <= min_nxt;
      flush_r      <= flush_nxt;
      flush_sec_r  <= flush_sec_nxt;
      s1_vld_r     <= s1_vld_nxt;
      out_vld_r    <= nrm_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_d_r      <= s1_d_nxt;
      s1_meta_r   <= s1_meta_nxt;
      out_value_r <= nrm_value;
      out_meta_r  <= nrm_meta;
    end
  end

  rsmp_norm u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_vld    (s1_vld_r),
    .in_d      (s1_d_r),
    .in_meta   (s1_meta_r),
    .res_vld   (nrm_vld),
    .res_value (nrm_value),
    .res_meta  (nrm_meta)
  );

  assign out_ch.valid         = out_vld_r;
  assign out_ch.sector_value  = out_value_r;
  assign out_ch.sector_number = out_meta_r.sector;
  assign out_ch.scan_done     = out_meta_r.done;

  a_flush_after_restart: assert property (@(posedge clk) disable iff (!rst_n)
    flush_r |-> (sample_cnt_r == '0 && cur_sector_r == '0 && flush_sec_r != '0))
    else $error("flush running without a restarted scan");

  a_sector_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cur_sector_r <= SECTOR_END && flush_sec_r <= LAST_SECTOR)
    else $error("sector counter beyond the last sector");

  a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_meta_r.done) |-> out_meta_r.sector == LAST_SECTOR)
    else $error("scan end flagged on a sector other than the last");

  a_full_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_meta_r.full) |->
      out_value_r == rsmp_pkg::VALUE_W'(rsmp_pkg::FULL_SCALE))
    else $error("unreached sector not reported as full scale");

endmodule

// File: tb/range_sector_min_pool_core_test.sv
// Self-checking testbench of range_sector_min_pool_core: predicted sector minima per request.
`timescale 1ns / 1ps

module range_sector_min_pool_core_test;
  import rsmp_pkg::*;

  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic [SECTOR_W-1:0] number;
    logic                done;
  } sector_result_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [LEN_W-1:0]  cfg_wr_data;

  rsmp_in_if  in_ch ();
  rsmp_out_if out_ch ();

  range_sector_min_pool_core i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  always #6 clk = ~clk;

  // pooling state mirrored from the block
  logic [LEN_W-1:0] scan_len_q;
  int unsigned      samples_seen;
  int unsigned      sector_idx;
  int unsigned      pos_in_sector;
  int unsigned      nearest_mm;

  sector_result_t pending_sectors[$];
  int             mismatch_count = 0;
  int             send_gap_pct   = 0;
  int             sink_stall_pct = 0;

  function automatic void queue_sector(input int unsigned value, input int unsigned sector);
    sector_result_t res;
    res.value  = value[VALUE_W-1:0];
    res.number = sector[SECTOR_W-1:0];
    res.done   = (sector + 1 == NUM_SECTORS);
    pending_sectors.push_back(res);
  endfunction

  function automatic void restart_scan_model();
    samples_seen  = 0;
    sector_idx    = 0;
    pos_in_sector = 0;
    nearest_mm    = RANGE_HI;
  endfunction

  function automatic void pool_sample(input logic [RANGE_WIDTH-1:0] range_mm,
                                      input logic finite);
    int unsigned n;
    int unsigned sec_w;
    int unsigned mm;
    bit          is_last;
    n       = (scan_len_q == '0) ? 1 : int'(scan_len_q);
    sec_w   = n / NUM_SECTORS;
    mm      = range_mm;
    is_last = (samples_seen + 1 >= n);
    if (sec_w == 0) sec_w = 1;
    if (sector_idx < NUM_SECTORS) begin
      if (finite) begin
        if (mm < RANGE_LO) mm = RANGE_LO;
        if (mm > RANGE_HI) mm = RANGE_HI;
        if (mm < nearest_mm) nearest_mm = mm;
      end
      if (pos_in_sector + 1 >= sec_w || is_last) begin
        queue_sector(((nearest_mm - RANGE_LO) * FULL_SCALE) / RANGE_SPAN, sector_idx);
        sector_idx++;
        pos_in_sector = 0;
        nearest_mm    = RANGE_HI;
      end else begin
        pos_in_sector = (pos_in_sector + 1) & 12'hFFF;
      end
    end
    if (is_last) begin
      // short scan: fill the sectors not reached with full scale
      while (sector_idx < NUM_SECTORS) begin
        queue_sector(FULL_SCALE, sector_idx);
        sector_idx++;
      end
      restart_scan_model();
    end else begin
      samples_seen = (samples_seen + 1) & 12'hFFF;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_sector();
    sector_result_t want;
    if (pending_sectors.size() == 0) begin
      report_mismatch($sformatf("unexpected result sector %0d value %0d",
                                out_ch.sector_number, out_ch.sector_value));
    end else begin
      want = pending_sectors.pop_front();
      if (out_ch.sector_value !== want.value)
        report_mismatch($sformatf("sector %0d value %0d, expected %0d",
                                  want.number, out_ch.sector_value, want.value));
      if (out_ch.sector_number !== want.number)
        report_mismatch($sformatf("sector number %0d, expected %0d",
                                  out_ch.sector_number, want.number));
      if (out_ch.scan_done !== want.done)
        report_mismatch($sformatf("sector %0d scan_done %0b, expected %0b",
                                  want.number, out_ch.scan_done, want.done));
    end
  endtask

  // result sink: values seen here are those before the edge
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) check_sector();
    out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  task automatic send_range(input logic [RANGE_WIDTH-1:0] range_mm, input logic finite);
    while ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.range_mm     <= range_mm;
    in_ch.range_finite <= finite;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pool_sample(range_mm, finite);
  endtask

  // drop valid, wait for every outstanding sector, then let the pipeline empty
  task automatic settle_block();
    in_ch.valid <= 1'b0;
    while (pending_sectors.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_scan_length(input logic [LEN_W-1:0] len);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    scan_len_q  = len;
  endtask

  function automatic logic [RANGE_WIDTH-1:0] rand_range_mm();
    case ($urandom_range(7))
      0:       return RANGE_WIDTH'($urandom_range(65535));
      1:       return RANGE_WIDTH'($urandom_range(499));
      2:       return RANGE_WIDTH'($urandom_range(65535, 10000));
      default: return RANGE_WIDTH'($urandom_range(10500, 400));
    endcase
  endfunction

  function automatic logic rand_finite();
    return ($urandom_range(9) != 0);
  endfunction

  function automatic logic [LEN_W-1:0] pick_scan_length();
    case ($urandom_range(9))
      0, 1:    return LEN_W'($urandom_range(35, 1));
      2:       return LEN_W'(NUM_SECTORS);
      3:       return '0;
      4:       return LEN_W'($urandom_range(300, 111));
      default: return LEN_W'($urandom_range(110, 37));
    endcase
  endfunction

  task automatic send_random_samples(input int count);
    repeat (count) send_range(rand_range_mm(), rand_finite());
  endtask

  // reset length first, then grow and shrink it while a scan is open
  task automatic test_length_change();
    send_random_samples(21);
    settle_block();
    set_scan_length('1);
    send_random_samples(30);
    settle_block();
    set_scan_length(LEN_W'(1));
    send_random_samples(1);
    settle_block();
  endtask

  task automatic test_field_extremes();
    set_scan_length(LEN_W'(18));
    send_range('0, 1'b1);
    send_range('1, 1'b1);
    send_range(RANGE_WIDTH'(499), 1'b1);
    send_range(RANGE_WIDTH'(500), 1'b1);
    send_range(RANGE_WIDTH'(501), 1'b1);
    send_range(RANGE_WIDTH'(9999), 1'b1);
    send_range(RANGE_WIDTH'(10000), 1'b1);
    send_range(RANGE_WIDTH'(10001), 1'b1);
    send_range(RANGE_WIDTH'(1234), 1'b0);
    send_range('0, 1'b0);
    send_range(RANGE_WIDTH'(16'h5555), 1'b1);
    send_range(RANGE_WIDTH'(16'hAAAA), 1'b1);
    send_range('1, 1'b0);
    send_range(RANGE_WIDTH'(9500), 1'b1);
    send_range(RANGE_WIDTH'(5250), 1'b1);
    send_range(RANGE_WIDTH'(10500), 1'b1);
    send_range(RANGE_WIDTH'(700), 1'b1);
    send_range(RANGE_WIDTH'(3000), 1'b1);
    settle_block();
  endtask

  // a zero length counts as one: every sample is a whole scan
  task automatic test_single_sample_scans();
    set_scan_length('0);
    send_range(RANGE_WIDTH'(7000), 1'b1);
    send_range(RANGE_WIDTH'(300), 1'b0);
    settle_block();
    set_scan_length(LEN_W'(1));
    send_range(RANGE_WIDTH'(10000), 1'b1);
    settle_block();
  endtask

  task automatic test_random_scans(input int gap_pct, input int stall_pct, input int n_items);
    int               sent;
    int               count;
    logic [LEN_W-1:0] len;
    sent           = 0;
    send_gap_pct   = gap_pct;
    sink_stall_pct = stall_pct;
    while (sent < n_items) begin
      len = pick_scan_length();
      set_scan_length(len);
      count = (len == '0) ? 1 : int'(len);
      // cut some scans short so the next length lands mid-scan
      if ($urandom_range(4) == 0) count = $urandom_range(count, 1);
      if (count > n_items - sent) count = n_items - sent;
      send_random_samples(count);
      sent += count;
      settle_block();
    end
  endtask

  initial begin
    rst_n              <= 1'b0;
    cfg_wr_en          <= 1'b0;
    cfg_wr_data        <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.range_mm     <= '0;
    in_ch.range_finite <= 1'b0;
    scan_len_q          = LEN_W'(720);
    restart_scan_model();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_length_change();
    test_field_extremes();
    test_single_sample_scans();
    test_random_scans(0, 0, 37);
    test_random_scans(47, 0, 37);
    test_random_scans(0, 47, 37);
    test_random_scans(29, 29, 37);

    settle_block();
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
